// ===== hdl/fit_policy_memory_allocator_unit_defines.svh =====
// Assertion macros for the allocator RTL.
// Included by modules that carry concurrent checks.
`ifndef FIT_POLICY_MEMORY_ALLOCATOR_UNIT_DEFINES_SVH
`define FIT_POLICY_MEMORY_ALLOCATOR_UNIT_DEFINES_SVH
// Assert an implication in the same cycle.
`define FPMA_ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("check failed");
// Assert an implication that must hold in the next cycle.
`define FPMA_ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("check failed");
`endif

// ===== hdl/fpma_pkg.sv =====
// Package for the fit-policy allocator: sizes, codes and shared types.
// No dependencies.
package fpma_pkg;
  localparam int MemUnits  = 1024;
  localparam int FreeSegs  = 32;
  localparam int AllocRecs = 32;
  localparam int AW = $clog2(MemUnits);
  localparam int FIW = $clog2(FreeSegs);
  localparam int AIW = $clog2(AllocRecs);
  localparam int FCW = $clog2(FreeSegs + 1);
  localparam int ACW = $clog2(AllocRecs + 1);
  localparam int PIDW = 16;
  localparam int SZW = 11;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_REL   = 2'd1;
  localparam logic [1:0] KIND_SFREE = 2'd2;
  localparam logic [1:0] KIND_SALOC = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_NOPID = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] POL_FIRST     = 2'd0;
  localparam logic [1:0] POL_BEST      = 2'd1;
  localparam logic [1:0] POL_WORST     = 2'd2;
  localparam logic [1:0] POL_FIRST_ALT = 2'd3;

  typedef struct packed {
    logic [PIDW-1:0] owner;
    logic [AW-1:0]   first;
    logic [AW-1:0]   last;
  } rec_t;

  // memory port bundle: one read and one write address per cycle
  typedef struct packed {
    logic          we;
    logic [7:0]    waddr;
    rec_t          wdata;
    logic [7:0]    raddr;
  } mport_t;
endpackage

// ===== hdl/fpma_ram.sv =====
// Generic one-write one-read synchronous RAM with registered read.
// Depends on nothing.
module fpma_ram #(
  parameter int Depth = 32,
  parameter int Width = 36
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== hdl/fpma_ctrl.sv =====
// Sequencer for the allocator: scans, shifts and updates both tables.
// Depends on fpma_pkg and the defines header; drives two fpma_ram ports.
`include "fit_policy_memory_allocator_unit_defines.svh"
module fpma_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [1:0]                policy_i,
  input  logic                      start_i,
  input  logic [1:0]                kind_i,
  input  logic [fpma_pkg::PIDW-1:0] pid_i,
  input  logic [fpma_pkg::SZW-1:0]  size_i,
  input  logic [fpma_pkg::AW-1:0]   rs_i,
  input  logic [fpma_pkg::AW-1:0]   re_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic [fpma_pkg::AW-1:0]   os_o,
  output logic [fpma_pkg::AW-1:0]   oe_o,
  output fpma_pkg::mport_t          fport_o,
  input  fpma_pkg::rec_t            frd_i,
  output fpma_pkg::mport_t          aport_o,
  input  fpma_pkg::rec_t            ard_i
);
  import fpma_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ASCAN = 5'd1;  // alloc: scan free table
  localparam logic [4:0] S_AFIN  = 5'd2;  // alloc: read chosen segment
  localparam logic [4:0] S_AGOT  = 5'd3;
  localparam logic [4:0] S_RSCAN = 5'd4;  // release: find owner
  localparam logic [4:0] S_PSCAN = 5'd6;  // add: find position p
  localparam logic [4:0] S_PPREV = 5'd7;  // add: read p-1
  localparam logic [4:0] S_PPRVD = 5'd8;
  localparam logic [4:0] S_PCUR  = 5'd9;  // add: read p
  localparam logic [4:0] S_PCURD = 5'd10;
  localparam logic [4:0] S_INS   = 5'd11; // shift up then write
  localparam logic [4:0] S_INSD  = 5'd12;
  localparam logic [4:0] S_MRG   = 5'd13; // check merge with k+1
  localparam logic [4:0] S_MRGD  = 5'd14;
  localparam logic [4:0] S_REM   = 5'd16; // shift down from rem index
  localparam logic [4:0] S_REMD  = 5'd17;
  localparam logic [4:0] S_POST  = 5'd18; // after add: follow-up
  localparam logic [4:0] S_DONE  = 5'd19;

  localparam logic [1:0] POST_NONE  = 2'd0;
  localparam logic [1:0] POST_ALLOC = 2'd1;
  localparam logic [1:0] POST_REL   = 2'd2;
  localparam logic [1:0] POST_TAIL  = 2'd3;

  logic [4:0]      st_q, st_d;
  logic [FCW-1:0]  fcnt_q, fcnt_d;
  logic [ACW-1:0]  acnt_q, acnt_d;
  logic [PIDW-1:0] pid_q, pid_d;
  logic [SZW-1:0]  size_q, size_d;
  logic [AW-1:0]   s_q, s_d, e_q, e_d;
  logic [8:0]      i_q, i_d;       // scan/shift index
  logic [8:0]      p_q, p_d;
  logic [8:0]      k_q, k_d;
  logic [8:0]      ch_q, ch_d;     // chosen segment / released record
  logic [SZW-1:0]  best_q, best_d;
  logic            fnd_q, fnd_d;
  logic            tfree_q, tfree_d; // add targets free table
  logic            rmw_q, rmw_d;     // remove targets free table
  logic [1:0]      stat_q, stat_d;
  logic [AW-1:0]   os_q, os_d, oe_q, oe_d;
  rec_t            kr_q, kr_d;       // entry k held
  rec_t            hold_q, hold_d;
  logic [1:0]      post_q, post_d;   // follow-up after an add

  rec_t            rd;
  logic [8:0]      cnt;
  logic [SZW-1:0]  seg;
  mport_t          fp, ap;

  assign rd  = tfree_q ? frd_i : ard_i;
  assign cnt = tfree_q ? 9'(fcnt_q) : 9'(acnt_q);
  assign seg = SZW'(frd_i.last) - SZW'(frd_i.first) + SZW'(1);

  always_comb begin
    st_d = st_q; fcnt_d = fcnt_q; acnt_d = acnt_q;
    pid_d = pid_q; size_d = size_q; s_d = s_q; e_d = e_q; i_d = i_q;
    p_d = p_q; k_d = k_q; ch_d = ch_q; best_d = best_q; fnd_d = fnd_q;
    tfree_d = tfree_q; rmw_d = rmw_q; stat_d = stat_q; os_d = os_q;
    oe_d = oe_q; kr_d = kr_q; hold_d = hold_q; post_d = post_q;
    fp = '0; ap = '0;
    case (st_q)
      S_IDLE: begin
        if (start_i) begin
          pid_d = pid_i; size_d = size_i;
          s_d = rs_i; e_d = re_i; i_d = '0; fnd_d = 1'b0;
          stat_d = ST_OK; os_d = '0; oe_d = '0; post_d = POST_NONE;
          case (kind_i)
            KIND_ALLOC: begin
              if (size_i == '0 || fcnt_q == '0) begin
                stat_d = ST_NOFIT; st_d = S_DONE;
              end else begin
                st_d = S_ASCAN;
              end
            end
            KIND_REL: st_d = (acnt_q == '0) ? S_DONE : S_RSCAN;
            default: begin
              tfree_d = (kind_i == KIND_SFREE);
              if (re_i < rs_i) begin
                stat_d = ST_NOFIT; st_d = S_DONE;
              end else begin
                st_d = S_PSCAN;
              end
            end
          endcase
          if (kind_i == KIND_REL) stat_d = ST_NOPID;
        end
      end
      S_ASCAN: begin
        fp.raddr = i_q[7:0];
        if (i_q > 9'd0 && !(fnd_q && policy_i != POL_BEST && policy_i != POL_WORST)) begin
          if (seg >= size_q) begin
            if (!fnd_q || (policy_i == POL_BEST && seg < best_q) ||
                (policy_i == POL_WORST && seg > best_q)) begin
              fnd_d = 1'b1; best_d = seg; ch_d = i_q - 9'd1;
            end
          end
        end
        if (i_q > 9'd0 && (i_q == 9'(fcnt_q) ||
            (fnd_d && policy_i != POL_BEST && policy_i != POL_WORST))) begin
          if (fnd_d) st_d = S_AFIN;
          else begin stat_d = ST_NOFIT; st_d = S_DONE; end
        end else begin
          i_d = i_q + 9'd1;
        end
      end
      S_AFIN: begin
        fp.raddr = ch_q[7:0];
        st_d = S_AGOT;
      end
      S_AGOT: begin
        hold_d = frd_i;
        s_d = frd_i.first;
        e_d = AW'(SZW'(frd_i.first) + size_q - SZW'(1));
        tfree_d = 1'b0; i_d = '0; post_d = POST_ALLOC;
        st_d = S_PSCAN;
      end
      S_RSCAN: begin
        ap.raddr = i_q[7:0];
        if (i_q > 9'd0 && ard_i.owner == pid_q) begin
          ch_d = i_q - 9'd1; s_d = ard_i.first; e_d = ard_i.last;
          tfree_d = 1'b1; i_d = '0; post_d = POST_REL; st_d = S_PSCAN;
        end else if (i_q == 9'(acnt_q)) begin
          st_d = S_DONE;
        end else begin
          i_d = i_q + 9'd1;
        end
      end
      S_PSCAN: begin
        fp.raddr = i_q[7:0]; ap.raddr = i_q[7:0];
        if (i_q > 9'd0 && !(rd.last < s_q)) begin
          p_d = i_q - 9'd1; st_d = S_PPREV;
        end else if (i_q == cnt) begin
          p_d = cnt; st_d = S_PPREV;
        end else begin
          i_d = i_q + 9'd1;
        end
      end
      S_PPREV: begin
        fp.raddr = 8'(p_q - 9'd1); ap.raddr = 8'(p_q - 9'd1);
        st_d = (p_q == 9'd0) ? S_PCUR : S_PPRVD;
      end
      S_PPRVD: begin
        if (AW'(rd.last + AW'(1)) == s_q && rd.last != '1 &&
            (tfree_q || rd.owner == pid_q)) begin
          k_d = p_q - 9'd1; kr_d = rd; kr_d.last = e_q;
          fp.we = tfree_q; ap.we = !tfree_q;
          fp.waddr = 8'(p_q - 9'd1); ap.waddr = 8'(p_q - 9'd1);
          fp.wdata = kr_d; ap.wdata = kr_d;
          st_d = S_MRG;
        end else begin
          st_d = S_PCUR;
        end
      end
      S_PCUR: begin
        fp.raddr = p_q[7:0]; ap.raddr = p_q[7:0];
        st_d = S_PCURD;
      end
      S_PCURD: begin
        if (p_q < cnt && e_q != '1 && AW'(e_q + AW'(1)) == rd.first &&
            (tfree_q || rd.owner == pid_q)) begin
          kr_d = rd; kr_d.first = s_q;
          fp.we = tfree_q; ap.we = !tfree_q;
          fp.waddr = p_q[7:0]; ap.waddr = p_q[7:0];
          fp.wdata = kr_d; ap.wdata = kr_d;
          st_d = S_POST;
        end else if (cnt == (tfree_q ? 9'(FreeSegs) : 9'(AllocRecs))) begin
          stat_d = ST_FULL; st_d = S_DONE;
        end else begin
          i_d = cnt; st_d = S_INS;
        end
      end
      S_INS: begin
        if (i_q == p_q) begin
          kr_d.owner = pid_q; kr_d.first = s_q; kr_d.last = e_q;
          fp.we = tfree_q; ap.we = !tfree_q;
          fp.waddr = p_q[7:0]; ap.waddr = p_q[7:0];
          fp.wdata = kr_d; ap.wdata = kr_d;
          k_d = p_q;
          if (tfree_q) fcnt_d = fcnt_q + FCW'(1);
          else acnt_d = acnt_q + ACW'(1);
          st_d = S_MRG;
        end else begin
          fp.raddr = 8'(i_q - 9'd1); ap.raddr = 8'(i_q - 9'd1);
          st_d = S_INSD;
        end
      end
      S_INSD: begin
        fp.we = tfree_q; ap.we = !tfree_q;
        fp.waddr = i_q[7:0]; ap.waddr = i_q[7:0];
        fp.wdata = rd; ap.wdata = rd;
        i_d = i_q - 9'd1; st_d = S_INS;
      end
      S_MRG: begin
        fp.raddr = 8'(k_q + 9'd1); ap.raddr = 8'(k_q + 9'd1);
        st_d = (k_q + 9'd1 < cnt) ? S_MRGD : S_POST;
      end
      S_MRGD: begin
        if (kr_q.last != '1 && AW'(kr_q.last + AW'(1)) == rd.first &&
            (tfree_q || rd.owner == pid_q)) begin
          kr_d.last = rd.last;
          fp.we = tfree_q; ap.we = !tfree_q;
          fp.waddr = k_q[7:0]; ap.waddr = k_q[7:0];
          fp.wdata = kr_d; ap.wdata = kr_d;
          rmw_d = tfree_q; i_d = k_q + 9'd1; st_d = S_REM;
        end else begin
          st_d = S_POST;
        end
      end
      S_REM: begin
        if (i_q + 9'd1 >= (rmw_q ? 9'(fcnt_q) : 9'(acnt_q))) begin
          if (rmw_q) fcnt_d = fcnt_q - FCW'(1);
          else acnt_d = acnt_q - ACW'(1);
          st_d = (rmw_q == tfree_q && post_q != POST_TAIL) ? S_POST : S_DONE;
        end else begin
          fp.raddr = 8'(i_q + 9'd1); ap.raddr = 8'(i_q + 9'd1);
          st_d = S_REMD;
        end
      end
      S_REMD: begin
        fp.we = rmw_q; ap.we = !rmw_q;
        fp.waddr = i_q[7:0]; ap.waddr = i_q[7:0];
        fp.wdata = rmw_q ? frd_i : ard_i; ap.wdata = fp.wdata;
        i_d = i_q + 9'd1; st_d = S_REM;
      end
      S_POST: begin
        os_d = s_q; oe_d = e_q; stat_d = ST_OK;
        case (post_q)
          POST_ALLOC: begin
            os_d = hold_q.first; oe_d = e_q;
            if (best_q == size_q) begin
              rmw_d = 1'b1; i_d = ch_q; post_d = POST_TAIL; st_d = S_REM;
            end else begin
              kr_d = hold_q; kr_d.first = AW'(SZW'(hold_q.first) + size_q);
              fp.we = 1'b1; fp.waddr = ch_q[7:0]; fp.wdata = kr_d;
              st_d = S_DONE;
            end
          end
          POST_REL: begin
            rmw_d = 1'b0; i_d = ch_q; post_d = POST_TAIL; st_d = S_REM;
          end
          default: st_d = S_DONE;
        endcase
      end
      S_DONE: begin
        if (stat_q != ST_OK) begin os_d = '0; oe_d = '0; end
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; fcnt_q <= '0; acnt_q <= '0;
    end else begin
      st_q <= st_d; fcnt_q <= fcnt_d; acnt_q <= acnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pid_q <= pid_d; size_q <= size_d; s_q <= s_d; e_q <= e_d;
    i_q <= i_d; p_q <= p_d; k_q <= k_d; ch_q <= ch_d; best_q <= best_d;
    fnd_q <= fnd_d; tfree_q <= tfree_d; rmw_q <= rmw_d; stat_q <= stat_d;
    os_q <= os_d; oe_q <= oe_d; kr_q <= kr_d; hold_q <= hold_d; post_q <= post_d;
  end

  assign fport_o  = fp;
  assign aport_o  = ap;
  assign busy_o   = (st_q != S_IDLE);
  assign done_o   = (st_q == S_DONE);
  assign status_o = stat_q;
  assign os_o     = (stat_q == ST_OK) ? os_q : '0;
  assign oe_o     = (stat_q == ST_OK) ? oe_q : '0;

  `FPMA_ASSERT_IMP(a_fcnt_max, clk_i, rst_ni, 1'b1, fcnt_q <= FCW'(FreeSegs))
  `FPMA_ASSERT_IMP(a_acnt_max, clk_i, rst_ni, 1'b1, acnt_q <= ACW'(AllocRecs))
  `FPMA_ASSERT_IMP(a_one_we, clk_i, rst_ni, fp.we, !ap.we)
  `FPMA_ASSERT_NXT(a_idle_cnt, clk_i, rst_ni, st_q == S_IDLE && !start_i,
                   $stable(fcnt_q) && $stable(acnt_q))
endmodule

// ===== hdl/fit_policy_memory_allocator_unit.sv =====
// Top level of the fit-policy contiguous allocator: stream ports, output register.
// Depends on fpma_pkg, fpma_ctrl and fpma_ram.
// One transaction is processed at a time: s_axis_tready stays low while an item is in
// the sequencer or its result waits on the master side. The sequencer reads each table
// through one synchronous RAM port one entry per cycle, and an insert or a remove
// shifts entries one by one. The longest item is an allocate that scans a full free
// table, inserts at the front of a record table holding 31 entries and then removes the
// chosen segment from the front of the free table. No clearing pass after reset.
module fit_policy_memory_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,  // kind
  input  logic [47:0] s_axis_tdata,  // proc_id[15:0], req_size[26:16],
                                     // region_start[36:27], region_end[46:37], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [1:0]  m_axis_tuser,  // status
  output logic [23:0] m_axis_tdata   // out_start[9:0], out_end[19:10], zero pad
);
  import fpma_pkg::*;

  logic [1:0]  pol_q;
  logic        busy, done, start;
  logic [1:0]  status;
  logic [AW-1:0] os, oe;
  mport_t      fp, ap;
  rec_t        frd, ard;

  assign s_axis_tready = !busy && !m_axis_tvalid;
  assign start = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q <= '0; m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we_i) pol_q <= cfg_wdata_i;
      if (done) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      m_axis_tuser <= status;
      m_axis_tdata <= {4'd0, oe, os};
    end
  end

  fpma_ctrl u_ctrl (
    .clk_i, .rst_ni, .policy_i(pol_q), .start_i(start),
    .kind_i(s_axis_tuser), .pid_i(s_axis_tdata[15:0]),
    .size_i(s_axis_tdata[26:16]), .rs_i(s_axis_tdata[36:27]), .re_i(s_axis_tdata[46:37]),
    .busy_o(busy), .done_o(done), .status_o(status), .os_o(os), .oe_o(oe),
    .fport_o(fp), .frd_i(frd), .aport_o(ap), .ard_i(ard)
  );

  fpma_ram #(.Depth(FreeSegs), .Width($bits(rec_t))) u_free (
    .clk_i, .we_i(fp.we), .waddr_i(fp.waddr[FIW-1:0]), .wdata_i(fp.wdata),
    .raddr_i(fp.raddr[FIW-1:0]), .rdata_o(frd)
  );

  fpma_ram #(.Depth(AllocRecs), .Width($bits(rec_t))) u_alloc (
    .clk_i, .we_i(ap.we), .waddr_i(ap.waddr[AIW-1:0]), .wdata_i(ap.wdata),
    .raddr_i(ap.raddr[AIW-1:0]), .rdata_o(ard)
  );
endmodule
